@@ rtl/lla_pkg.sv @@
// Shared types, codes and cell rule functions for the life-like automaton.
`timescale 1ns / 1ps

package lla_pkg;

   // default storage geometry
   localparam int DEF_MAX_COLS = 64;
   localparam int DEF_MAX_ROWS = 64;
   localparam int DEF_HISTORY  = 4;
   localparam int MIN_HISTORY  = 2;

   localparam int CELL_W     = 3;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // cell codes
   localparam logic [CELL_W-1:0] CELL_DEAD  = 3'd0;
   localparam logic [CELL_W-1:0] CELL_ALIVE = 3'd1;
   localparam logic [CELL_W-1:0] CELL_NEW   = 3'd2;
   localparam logic [CELL_W-1:0] CELL_DIED  = 3'd3;
   localparam logic [CELL_W-1:0] CELL_UNDEF = 3'd4;

   // rule actions
   localparam logic [1:0] ACT_DIE    = 2'd0;
   localparam logic [1:0] ACT_CREATE = 2'd1;
   localparam logic [1:0] ACT_KEEP   = 2'd2;
   localparam logic [1:0] ACT_TOGGLE = 2'd3;

   // register indexes
   localparam logic [2:0] REG_GRID_WIDTH   = 3'd0;
   localparam logic [2:0] REG_GRID_HEIGHT  = 3'd1;
   localparam logic [2:0] REG_RULE_TABLE   = 3'd2;
   localparam logic [2:0] REG_PERIOD_CHECK = 3'd3;
   localparam logic [2:0] REG_HISTORY_USED = 3'd4;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_STEP  = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef struct packed {
      logic [6:0]  grid_width;
      logic [6:0]  grid_height;
      logic [17:0] rule_table;
      logic        period_check_on;
      logic [2:0]  history_used;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic start_op;
      logic clr_write;
      logic wr_cell;
      logic rd_cell;
      logic rd_capture;
      logic row_start;
      logic load_tick;
      logic fill_tick;
      logic row_next;
      logic step_commit;
      logic cmp_start;
      logic cmp_issue;
      logic cmp_next;
      logic set_found;
      logic out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic   clr_last;
      op_type op;
      logic   row_in_grid;
      logic   load_done;
      logic   fill_done;
      logic   row_last;
      logic   cmp_last;
      logic   mismatch;
      logic   lag_last;
      logic   check_on;
   } status_type;

   // new counts as alive, died as dead
   function automatic logic [CELL_W-1:0] settle(input logic [CELL_W-1:0] code);
      logic [CELL_W-1:0] s;
      case (code)
         CELL_NEW:  s = CELL_ALIVE;
         CELL_DIED: s = CELL_DEAD;
         default:   s = code;
      endcase
      return s;
   endfunction

   function automatic logic is_live(input logic [CELL_W-1:0] code);
      return (code == CELL_ALIVE) || (code == CELL_NEW);
   endfunction

   function automatic logic [CELL_W-1:0] next_code(input logic [17:0] rule,
                                                   input logic [3:0]  count,
                                                   input logic        live);
      logic [1:0] act;
      act = 2'(rule >> {count, 1'b0});
      if (live) begin
         return (act == ACT_CREATE || act == ACT_KEEP) ? CELL_ALIVE : CELL_DIED;
      end
      return (act == ACT_CREATE || act == ACT_TOGGLE) ? CELL_NEW : CELL_DEAD;
   endfunction

   // two cells differ, or either is undefined
   function automatic logic cell_differs(input logic [CELL_W-1:0] x,
                                         input logic [CELL_W-1:0] y);
      logic [CELL_W-1:0] a;
      logic [CELL_W-1:0] b;
      a = settle(x);
      b = settle(y);
      return (a == CELL_UNDEF) || (b == CELL_UNDEF) || (a != b);
   endfunction

endpackage

@@ rtl/lla_ram.sv @@
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps

module lla_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ rtl/lla_ctrl.sv @@
// Controller: sequences clearing, cell access, generation step and period search.
`timescale 1ns / 1ps

module lla_ctrl
   import lla_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output cmd_type    cmd,
   input  status_type status
);

   typedef enum logic [13:0] {
      S_CLEAR     = 14'b00000000000001,
      S_IDLE      = 14'b00000000000010,
      S_DISPATCH  = 14'b00000000000100,
      S_WRITE     = 14'b00000000001000,
      S_RD_ISSUE  = 14'b00000000010000,
      S_RD_WAIT   = 14'b00000000100000,
      S_ROW_START = 14'b00000001000000,
      S_LOAD      = 14'b00000010000000,
      S_FILL      = 14'b00000100000000,
      S_CMP_START = 14'b00001000000000,
      S_CMP_ISSUE = 14'b00010000000000,
      S_CMP_DRAIN = 14'b00100000000000,
      S_CMP_DEC   = 14'b01000000000000,
      S_DONE      = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (status.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.start_op = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (status.op)
               OP_WRITE: state_in = S_WRITE;
               OP_STEP:  state_in = S_ROW_START;
               OP_READ:  state_in = S_RD_ISSUE;
               default:  state_in = S_DONE;
            endcase
         end
         S_WRITE: begin
            cmd.wr_cell = 1'b1;
            state_in    = S_DONE;
         end
         S_RD_ISSUE: begin
            cmd.rd_cell = 1'b1;
            state_in    = S_RD_WAIT;
         end
         S_RD_WAIT: begin
            cmd.rd_capture = 1'b1;
            state_in       = S_DONE;
         end
         S_ROW_START: begin
            cmd.row_start = 1'b1;
            state_in      = status.row_in_grid ? S_LOAD : S_FILL;
         end
         S_LOAD: begin
            cmd.load_tick = 1'b1;
            if (status.load_done) state_in = S_FILL;
         end
         S_FILL: begin
            if (!status.fill_done) begin
               cmd.fill_tick = 1'b1;
            end else if (status.row_last) begin
               cmd.step_commit = 1'b1;
               state_in        = status.check_on ? S_CMP_START : S_DONE;
            end else begin
               cmd.row_next = 1'b1;
               state_in     = S_ROW_START;
            end
         end
         S_CMP_START: begin
            cmd.cmp_start = 1'b1;
            state_in      = S_CMP_ISSUE;
         end
         S_CMP_ISSUE: begin
            cmd.cmp_issue = 1'b1;
            if (status.cmp_last) state_in = S_CMP_DRAIN;
         end
         S_CMP_DRAIN: begin
            state_in = S_CMP_DEC;
         end
         S_CMP_DEC: begin
            if (!status.mismatch) begin
               cmd.set_found = 1'b1;
               state_in      = S_DONE;
            end else if (status.lag_last) begin
               state_in = S_DONE;
            end else begin
               cmd.cmp_next = 1'b1;
               state_in     = S_CMP_ISSUE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/lla_dp.sv @@
// Datapath: generation store, scan counters, 3x3 window, compare and result words.
`timescale 1ns / 1ps

module lla_dp
   import lla_pkg::*;
#(
   parameter int MAX_COLS = DEF_MAX_COLS,
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   parameter int HISTORY  = DEF_HISTORY
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic [1:0]        req_opcode,
   input  logic [5:0]        req_col,
   input  logic [5:0]        req_row,
   input  logic              req_write_alive,
   input  cmd_type           cmd,
   output status_type        status,
   output logic [CELL_W-1:0] rsp_cell_value,
   output logic              rsp_period_found,
   output logic [1:0]        rsp_period_lag
);

   localparam int ColW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RowW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int SlotW    = $clog2(HISTORY);
   localparam int ColCntW  = $clog2(MAX_COLS + 1);
   localparam int RowCntW  = $clog2(MAX_ROWS + 1);
   localparam int HistCntW = $clog2(HISTORY + 1);
   localparam int AddrW    = SlotW + RowW + ColW;
   localparam int Depth    = 1 << AddrW;
   localparam longint ClrLast = longint'(HISTORY) * (longint'(1) << (RowW + ColW)) - 1;

   // column load phases
   localparam logic [2:0] PH_UP    = 3'd0;
   localparam logic [2:0] PH_MID   = 3'd1;
   localparam logic [2:0] PH_DOWN  = 3'd2;
   localparam logic [2:0] PH_TAIL  = 3'd3;
   localparam logic [2:0] PH_SHIFT = 3'd4;

   logic [AddrW-1:0]    clr_ff;
   logic [SlotW-1:0]    newest_ff;
   logic [RowW-1:0]     row_ff;
   logic [ColCntW-1:0]  ldcol_ff;
   logic [2:0]          ph_ff;
   logic [SlotW-1:0]    lag_ff;
   logic                mismatch_ff;
   logic                pend_ff;
   logic [2:0][2:0]     win_ff;
   logic [2:0]          colbits_ff;
   op_type              op_ff;
   logic [5:0]          op_col_ff;
   logic [5:0]          op_row_ff;
   logic                op_wa_ff;
   logic [CELL_W-1:0]   res_cell_ff;
   logic                res_found_ff;
   logic [1:0]          res_lag_ff;
   logic [CELL_W-1:0]   out_cell_ff;
   logic                out_found_ff;
   logic [1:0]          out_lag_ff;

   logic [6:0]          gw_min, gh_min;
   logic [2:0]          hist_min;
   logic [ColCntW-1:0]  used_cols;
   logic [RowCntW-1:0]  used_rows;
   logic [HistCntW-1:0] used_hist;
   logic                in_grid;
   logic [SlotW-1:0]    dst_slot, past_slot;
   logic [2:0][2:0]     nwin;
   logic [3:0]          count;
   logic [CELL_W-1:0]   new_code;
   logic [ColCntW-1:0]  prev_col;
   logic                col_ok, up_ok, dn_ok, rd_live, last_col;
   logic [2:0]          colbits_in;

   logic                wr_en;
   logic [AddrW-1:0]    wr_addr, rd_addr_a, rd_addr_b;
   logic [CELL_W-1:0]   wr_data, rd_a, rd_b;

   // saturated configuration
   always_comb begin
      gw_min    = (cfg.grid_width == '0) ? 7'd1 : cfg.grid_width;
      gh_min    = (cfg.grid_height == '0) ? 7'd1 : cfg.grid_height;
      hist_min  = (int'(cfg.history_used) < MIN_HISTORY) ? 3'(MIN_HISTORY)
                                                         : cfg.history_used;
      used_cols = (int'(gw_min) > MAX_COLS) ? ColCntW'(MAX_COLS) : ColCntW'(gw_min);
      used_rows = (int'(gh_min) > MAX_ROWS) ? RowCntW'(MAX_ROWS) : RowCntW'(gh_min);
      used_hist = (int'(hist_min) > HISTORY) ? HistCntW'(HISTORY) : HistCntW'(hist_min);
   end

   assign in_grid = (int'(op_col_ff) < int'(used_cols)) && (int'(op_row_ff) < int'(used_rows));

   // ring slots
   assign dst_slot  = (int'(newest_ff) == HISTORY - 1) ? '0 : newest_ff + SlotW'(1);
   assign past_slot = (newest_ff >= lag_ff) ? newest_ff - lag_ff
                    : SlotW'(int'(newest_ff) + HISTORY - int'(lag_ff));

   // window after shifting in the loaded column
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         nwin[k][0] = win_ff[k][1];
         nwin[k][1] = win_ff[k][2];
         nwin[k][2] = colbits_ff[k];
      end
      count = 4'(nwin[0][0]) + 4'(nwin[0][1]) + 4'(nwin[0][2]) + 4'(nwin[1][0])
            + 4'(nwin[1][2]) + 4'(nwin[2][0]) + 4'(nwin[2][1]) + 4'(nwin[2][2]);
      new_code = next_code(cfg.rule_table, count, nwin[1][1]);
   end

   assign prev_col = ldcol_ff - ColCntW'(1);
   assign col_ok   = ldcol_ff < used_cols;
   assign up_ok    = row_ff != '0;
   assign dn_ok    = (RowCntW'(row_ff) + RowCntW'(1)) < used_rows;
   assign rd_live  = is_live(rd_a);
   assign last_col = ldcol_ff == used_cols - ColCntW'(1);

   // column capture from read data
   always_comb begin
      colbits_in = colbits_ff;
      case (ph_ff)
         PH_MID:  colbits_in[0] = rd_live & col_ok & up_ok;
         PH_DOWN: colbits_in[1] = rd_live & col_ok;
         PH_TAIL: colbits_in[2] = rd_live & col_ok & dn_ok;
         default: colbits_in = colbits_ff;
      endcase
   end

   // write port select
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = CELL_DEAD;
      if (cmd.clr_write) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = (clr_ff[AddrW-1 -: SlotW] == '0) ? CELL_DEAD : CELL_UNDEF;
      end else if (cmd.wr_cell && in_grid) begin
         wr_en   = 1'b1;
         wr_addr = {newest_ff, RowW'(op_row_ff), ColW'(op_col_ff)};
         wr_data = op_wa_ff ? CELL_ALIVE : CELL_DEAD;
      end else if (cmd.load_tick && ph_ff == PH_SHIFT && ldcol_ff != '0) begin
         wr_en   = 1'b1;
         wr_addr = {dst_slot, row_ff, prev_col[ColW-1:0]};
         wr_data = new_code;
      end else if (cmd.fill_tick && !status.fill_done) begin
         wr_en   = 1'b1;
         wr_addr = {dst_slot, row_ff, ldcol_ff[ColW-1:0]};
         wr_data = CELL_DEAD;
      end
   end

   // read port select
   always_comb begin
      if (cmd.rd_cell) begin
         rd_addr_a = {newest_ff, RowW'(op_row_ff), ColW'(op_col_ff)};
      end else if (cmd.load_tick) begin
         rd_addr_a = {newest_ff, RowW'(int'(row_ff) + int'(ph_ff) - 1),
                      ldcol_ff[ColW-1:0]};
      end else begin
         rd_addr_a = {newest_ff, row_ff, ldcol_ff[ColW-1:0]};
      end
      rd_addr_b = {past_slot, row_ff, ldcol_ff[ColW-1:0]};
   end

   lla_ram #(
      .WIDTH(CELL_W),
      .DEPTH(Depth)
   ) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr_a(rd_addr_a),
      .rd_data_a(rd_a),
      .rd_addr_b(rd_addr_b),
      .rd_data_b(rd_b)
   );

   // control counters
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         newest_ff   <= '0;
         row_ff      <= '0;
         ldcol_ff    <= '0;
         ph_ff       <= PH_UP;
         lag_ff      <= '0;
         mismatch_ff <= 1'b0;
         pend_ff     <= 1'b0;
         op_ff       <= OP_NONE;
      end else begin
         pend_ff <= cmd.cmp_issue;
         if (cmd.clr_write) clr_ff <= clr_ff + AddrW'(1);
         if (cmd.start_op) op_ff <= op_type'(req_opcode);
         if (cmd.step_commit) newest_ff <= dst_slot;

         // row counter
         if (cmd.start_op || cmd.cmp_start || cmd.cmp_next) begin
            row_ff <= '0;
         end else if (cmd.row_next || (cmd.cmp_issue && last_col)) begin
            row_ff <= row_ff + RowW'(1);
         end

         // column counter
         if (cmd.row_start || cmd.cmp_start || cmd.cmp_next) begin
            ldcol_ff <= '0;
         end else if (cmd.load_tick && ph_ff == PH_SHIFT && ldcol_ff != used_cols) begin
            ldcol_ff <= ldcol_ff + ColCntW'(1);
         end else if (cmd.fill_tick && !status.fill_done) begin
            ldcol_ff <= ldcol_ff + ColCntW'(1);
         end else if (cmd.cmp_issue) begin
            ldcol_ff <= last_col ? '0 : ldcol_ff + ColCntW'(1);
         end

         // load phase
         if (cmd.row_start) begin
            ph_ff <= PH_UP;
         end else if (cmd.load_tick) begin
            ph_ff <= (ph_ff == PH_SHIFT) ? PH_UP : ph_ff + 3'd1;
         end

         // lag and match tracking
         if (cmd.cmp_start) begin
            lag_ff <= SlotW'(1);
         end else if (cmd.cmp_next) begin
            lag_ff <= lag_ff + SlotW'(1);
         end
         if (cmd.cmp_start || cmd.cmp_next) begin
            mismatch_ff <= 1'b0;
         end else if (pend_ff && cell_differs(rd_a, rd_b)) begin
            mismatch_ff <= 1'b1;
         end
      end
   end

   // window, request fields and result words
   always_ff @(posedge clock) begin
      if (cmd.row_start) begin
         win_ff     <= '0;
         colbits_ff <= '0;
      end else if (cmd.load_tick) begin
         colbits_ff <= colbits_in;
         if (ph_ff == PH_SHIFT) win_ff <= nwin;
      end
      if (cmd.start_op) begin
         op_col_ff    <= req_col;
         op_row_ff    <= req_row;
         op_wa_ff     <= req_write_alive;
         res_cell_ff  <= CELL_DEAD;
         res_found_ff <= 1'b0;
         res_lag_ff   <= '0;
      end else if (cmd.rd_capture) begin
         res_cell_ff <= in_grid ? rd_a : CELL_DEAD;
      end else if (cmd.set_found) begin
         res_found_ff <= 1'b1;
         res_lag_ff   <= 2'(lag_ff);
      end
      if (cmd.out_load) begin
         out_cell_ff  <= res_cell_ff;
         out_found_ff <= res_found_ff;
         out_lag_ff   <= res_lag_ff;
      end
   end

   assign rsp_cell_value   = out_cell_ff;
   assign rsp_period_found = out_found_ff;
   assign rsp_period_lag   = out_lag_ff;

   // status back to the controller
   always_comb begin
      status.clr_last    = clr_ff == AddrW'(ClrLast);
      status.op          = op_ff;
      status.row_in_grid = RowCntW'(row_ff) < used_rows;
      status.load_done   = (ph_ff == PH_SHIFT) && (ldcol_ff == used_cols);
      status.fill_done   = ldcol_ff == ColCntW'(MAX_COLS);
      status.row_last    = int'(row_ff) == MAX_ROWS - 1;
      status.cmp_last    = (RowCntW'(row_ff) == used_rows - RowCntW'(1)) && last_col;
      status.mismatch    = mismatch_ff;
      status.lag_last    = HistCntW'(lag_ff) == used_hist - HistCntW'(1);
      status.check_on    = cfg.period_check_on;
   end

endmodule

@@ rtl/life_like_automaton_with_period_detect.sv @@
// Top level: register port, controller, datapath and checks of the automaton.
`timescale 1ns / 1ps

// Life-like cellular automaton with period detection.
// Input words (req_*) carry an opcode: write a cell, step one generation,
// or read a cell. Every input word yields exactly one result word (rsp_*).
// A word is taken when valid is high and stall is low; one word is worked on
// at a time, and a new one may be taken while the last result still waits.
// A step on a W x H grid in use builds the new generation through the 3x3
// window (three store reads per column), writes dead cells to the rest of
// the MAX_ROWS x MAX_COLS slot, then, with the period search on, compares
// the grid in use against each lag checked, one cell pair a cycle from the
// two read ports. All cells live in one RAM.
// Reset loads the registers with their defaults and starts a clearing pass over
// HISTORY * 2**(row bits + column bits) store entries (16384 at the defaults) that
// makes the current generation dead and the others undefined; no word is
// taken meanwhile, register writes are.
// A stalled result holds; the finished word after it waits inside.

module life_like_automaton_with_period_detect
   import lla_pkg::*;
#(
   parameter int MAX_COLS = DEF_MAX_COLS,
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   parameter int HISTORY  = DEF_HISTORY
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_opcode,
   input  logic [5:0]            req_col,
   input  logic [5:0]            req_row,
   input  logic                  req_write_alive,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CELL_W-1:0]     rsp_cell_value,
   output logic                  rsp_period_found,
   output logic [1:0]            rsp_period_lag,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg_ff;
   cmd_type    cmd;
   status_type status;
   logic [2:0] csr_index;
   logic       csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_width      <= 7'd64;
         cfg_ff.grid_height     <= 7'd64;
         cfg_ff.rule_table      <= '0;
         cfg_ff.period_check_on <= 1'b1;
         cfg_ff.history_used    <= 3'd2;
      end else if (csr_write) begin
         case (csr_index)
            REG_GRID_WIDTH:   cfg_ff.grid_width      <= csr_pwdata[6:0];
            REG_GRID_HEIGHT:  cfg_ff.grid_height     <= csr_pwdata[6:0];
            REG_RULE_TABLE:   cfg_ff.rule_table      <= csr_pwdata[17:0];
            REG_PERIOD_CHECK: cfg_ff.period_check_on <= csr_pwdata[0];
            REG_HISTORY_USED: cfg_ff.history_used    <= csr_pwdata[2:0];
            default:          cfg_ff.history_used    <= cfg_ff.history_used;
         endcase
      end
   end

   // register reads
   always_comb begin
      case (csr_index)
         REG_GRID_WIDTH:   csr_prdata = CSR_DATA_W'(cfg_ff.grid_width);
         REG_GRID_HEIGHT:  csr_prdata = CSR_DATA_W'(cfg_ff.grid_height);
         REG_RULE_TABLE:   csr_prdata = CSR_DATA_W'(cfg_ff.rule_table);
         REG_PERIOD_CHECK: csr_prdata = CSR_DATA_W'(cfg_ff.period_check_on);
         REG_HISTORY_USED: csr_prdata = CSR_DATA_W'(cfg_ff.history_used);
         default:          csr_prdata = '0;
      endcase
   end

   lla_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .cmd      (cmd),
      .status   (status)
   );

   lla_dp #(
      .MAX_COLS(MAX_COLS),
      .MAX_ROWS(MAX_ROWS),
      .HISTORY (HISTORY)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_opcode      (req_opcode),
      .req_col         (req_col),
      .req_row         (req_row),
      .req_write_alive (req_write_alive),
      .cmd             (cmd),
      .status          (status),
      .rsp_cell_value  (rsp_cell_value),
      .rsp_period_found(rsp_period_found),
      .rsp_period_lag  (rsp_period_lag)
   );

   // clearing pass holds off input words right after reset
   a_clear_stalls: assert property (@(posedge clock) reset |=> req_stall)
      else $error("input taken during clearing pass");

   // an accepted word keeps the block busy on the next cycle
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word taken back to back");

   // a found period reports a nonzero lag when HISTORY is at most 4
   a_found_lag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_period_found |-> rsp_period_lag != 2'd0 || HISTORY > 4)
      else $error("period found with zero lag");

endmodule

@@ test/lla_checker.sv @@
// Checker for the automaton: tracks cell state, predicts each result word, compares.
`timescale 1ns / 1ps

module lla_checker
   import lla_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [1:0]            req_opcode,
   input  logic [5:0]            req_col,
   input  logic [5:0]            req_row,
   input  logic                  req_write_alive,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [CELL_W-1:0]     rsp_cell_value,
   input  logic                  rsp_period_found,
   input  logic [1:0]            rsp_period_lag,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    errors,
   output int                    pending
);

   localparam int NCOLS = DEF_MAX_COLS;
   localparam int NROWS = DEF_MAX_ROWS;
   localparam int NGEN  = DEF_HISTORY;

   typedef struct packed {
      logic [CELL_W-1:0] code;
      logic              found;
      logic [1:0]        lag;
   } answer_type;

   // generation ring and shadow registers
   logic [CELL_W-1:0] gens [NGEN][NROWS*NCOLS];
   int                newest;
   cfg_type           cfg;
   answer_type        answers [$];

   function automatic int cols_in_use();
      if (cfg.grid_width < 1) return 1;
      if (cfg.grid_width > NCOLS) return NCOLS;
      return int'(cfg.grid_width);
   endfunction

   function automatic int rows_in_use();
      if (cfg.grid_height < 1) return 1;
      if (cfg.grid_height > NROWS) return NROWS;
      return int'(cfg.grid_height);
   endfunction

   function automatic int depth_in_use();
      if (cfg.history_used < MIN_HISTORY) return MIN_HISTORY;
      if (cfg.history_used > NGEN) return NGEN;
      return int'(cfg.history_used);
   endfunction

   function automatic logic [CELL_W-1:0] settled(logic [CELL_W-1:0] c);
      if (c == CELL_NEW) return CELL_ALIVE;
      if (c == CELL_DIED) return CELL_DEAD;
      return c;
   endfunction

   function automatic int alive_at(int s, int c, int r, int w, int h);
      if (c < 0 || r < 0 || c >= w || r >= h) return 0;
      return (settled(gens[s][r*NCOLS+c]) == CELL_ALIVE) ? 1 : 0;
   endfunction

   // one generation step plus the period search
   task automatic advance(output logic found, output logic [1:0] lag);
      int w, h, src, dst, n, g, past;
      logic [1:0] act;
      logic same;
      logic [CELL_W-1:0] a, b;
      w = cols_in_use();
      h = rows_in_use();
      src = newest;
      dst = (src + 1) % NGEN;
      for (int r = 0; r < NROWS; r++) begin
         for (int c = 0; c < NCOLS; c++) begin
            if (r >= h || c >= w) begin
               gens[dst][r*NCOLS+c] = CELL_DEAD;
            end else begin
               n = 0;
               for (int dr = -1; dr <= 1; dr++)
                  for (int dc = -1; dc <= 1; dc++)
                     if (dr != 0 || dc != 0) n += alive_at(src, c+dc, r+dr, w, h);
               act = cfg.rule_table[2*n +: 2];
               if (settled(gens[src][r*NCOLS+c]) == CELL_ALIVE)
                  gens[dst][r*NCOLS+c] = (act == ACT_CREATE || act == ACT_KEEP) ?
                                         CELL_ALIVE : CELL_DIED;
               else
                  gens[dst][r*NCOLS+c] = (act == ACT_CREATE || act == ACT_TOGGLE) ?
                                         CELL_NEW : CELL_DEAD;
            end
         end
      end
      newest = dst;
      found = 1'b0;
      lag = 2'd0;
      if (cfg.period_check_on) begin
         for (g = 1; g < depth_in_use(); g++) begin
            past = (dst + NGEN - g) % NGEN;
            same = 1'b1;
            for (int r = 0; r < h && same; r++) begin
               for (int c = 0; c < w && same; c++) begin
                  a = settled(gens[dst][r*NCOLS+c]);
                  b = settled(gens[past][r*NCOLS+c]);
                  if (a == CELL_UNDEF || b == CELL_UNDEF || a != b) same = 1'b0;
               end
            end
            if (same) begin
               found = 1'b1;
               lag = 2'(g);
               return;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      answer_type want, got;
      logic in_grid;
      if (reset) begin
         newest = 0;
         for (int g = 0; g < NGEN; g++)
            for (int i = 0; i < NROWS*NCOLS; i++)
               gens[g][i] = (g == 0) ? CELL_DEAD : CELL_UNDEF;
         cfg = '{grid_width: 7'd64, grid_height: 7'd64, rule_table: '0,
                 period_check_on: 1'b1, history_used: 3'd2};
         answers.delete();
         errors = 0;
      end else begin
         // result side first: it always belongs to an older word
         if (rsp_valid && !rsp_stall) begin
            got = '{code: rsp_cell_value, found: rsp_period_found, lag: rsp_period_lag};
            if (answers.size() == 0) begin
               errors++;
               $display("%0t: unexpected result word cell=%0d found=%0d lag=%0d",
                        $time, got.code, got.found, got.lag);
            end else begin
               want = answers.pop_front();
               if (got.code !== want.code) begin
                  errors++;
                  $display("%0t: cell_value expected %0d got %0d", $time, want.code, got.code);
               end
               if (got.found !== want.found) begin
                  errors++;
                  $display("%0t: period_found expected %0d got %0d", $time,
                           want.found, got.found);
               end
               if (got.lag !== want.lag) begin
                  errors++;
                  $display("%0t: period_lag expected %0d got %0d", $time, want.lag, got.lag);
               end
            end
         end
         // register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_W-1:2])
               REG_GRID_WIDTH:   cfg.grid_width = csr_pwdata[6:0];
               REG_GRID_HEIGHT:  cfg.grid_height = csr_pwdata[6:0];
               REG_RULE_TABLE:   cfg.rule_table = csr_pwdata[17:0];
               REG_PERIOD_CHECK: cfg.period_check_on = csr_pwdata[0];
               REG_HISTORY_USED: cfg.history_used = csr_pwdata[2:0];
               default: ;
            endcase
         end
         // accepted input word
         if (req_valid && !req_stall) begin
            want = '0;
            in_grid = (int'(req_col) < cols_in_use()) && (int'(req_row) < rows_in_use());
            case (op_type'(req_opcode))
               OP_WRITE: if (in_grid)
                  gens[newest][req_row*NCOLS+req_col] = req_write_alive ? CELL_ALIVE : CELL_DEAD;
               OP_STEP:  advance(want.found, want.lag);
               OP_READ:  if (in_grid) want.code = gens[newest][req_row*NCOLS+req_col];
               default: ;
            endcase
            answers.push_back(want);
         end
      end
      pending = answers.size();
   end

endmodule

@@ test/tb.sv @@
// Testbench top: clock, reset, stimulus, register setup and verdict.
`timescale 1ns / 1ps

module tb;
   import lla_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_opcode = '0;
   logic [5:0]            req_col = '0;
   logic [5:0]            req_row = '0;
   logic                  req_write_alive = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CELL_W-1:0]     rsp_cell_value;
   logic                  rsp_period_found;
   logic [1:0]            rsp_period_lag;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    errors;
   int                    pending;
   logic                  jitter_on = 1'b1;
   int                    stall_left = 0;
   int                    words_sent = 0;
   int                    steps_sent = 0;
   int                    cur_w = 64;
   int                    cur_h = 64;

   localparam logic [17:0] RULE_CONWAY = (18'(ACT_KEEP) << 4) | (18'(ACT_CREATE) << 6);
   localparam logic [17:0] RULE_TOGGLE = 18'h3FFFF;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   life_like_automaton_with_period_detect uut (.*);

   lla_checker chk (.*);

   // result-side back-pressure in short random bursts
   always @(posedge clock) begin
      if (reset || !jitter_on) begin
         stall_left <= 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 4);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic configure(int w, int h, logic [17:0] rule, logic chk_on, int hist);
      csr_write(REG_GRID_WIDTH, w);
      csr_write(REG_GRID_HEIGHT, h);
      csr_write(REG_RULE_TABLE, 32'(rule));
      csr_write(REG_PERIOD_CHECK, 32'(chk_on));
      csr_write(REG_HISTORY_USED, hist);
      cur_w = (w < 1) ? 1 : (w > 64) ? 64 : w;
      cur_h = (h < 1) ? 1 : (h > 64) ? 64 : h;
   endtask

   // present one word and hold it until taken
   task automatic send(op_type op, int col, int row, logic alive);
      if (jitter_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_col <= 6'(col);
      req_row <= 6'(row);
      req_write_alive <= alive;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      if (op == OP_STEP) steps_sent++;
   endtask

   task automatic drain();
      @(posedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: defaults, full-size grid, corners, unknown opcode
      send(OP_READ, 0, 0, 1'b0);
      send(OP_READ, 63, 63, 1'b0);
      send(OP_WRITE, 0, 0, 1'b1);
      send(OP_WRITE, 63, 63, 1'b1);
      send(OP_READ, 0, 0, 1'b0);
      send(OP_NONE, 63, 63, 1'b1);
      send(OP_STEP, 0, 0, 1'b0);
      send(OP_READ, 63, 63, 1'b0);
      send(OP_STEP, 63, 63, 1'b1);
      drain();

      // blinker under the classic rule, deep history finds lag 2
      configure(5, 5, RULE_CONWAY, 1'b1, 4);
      send(OP_WRITE, 1, 2, 1'b1);
      send(OP_WRITE, 2, 2, 1'b1);
      send(OP_WRITE, 3, 2, 1'b1);
      send(OP_WRITE, 5, 2, 1'b1);
      send(OP_READ, 5, 2, 1'b0);
      send(OP_STEP, 0, 0, 1'b0);
      send(OP_READ, 2, 1, 1'b0);
      send(OP_READ, 1, 2, 1'b0);
      send(OP_STEP, 0, 0, 1'b0);
      send(OP_STEP, 0, 0, 1'b0);
      drain();

      // out-of-range sizes and history saturate; toggle rule; search off, then on
      configure(127, 1, RULE_TOGGLE, 1'b0, 7);
      send(OP_STEP, 0, 0, 1'b0);
      send(OP_READ, 63, 0, 1'b0);
      drain();
      configure(0, 0, RULE_TOGGLE, 1'b1, 0);
      send(OP_STEP, 0, 0, 1'b0);
      send(OP_STEP, 0, 0, 1'b0);
      send(OP_READ, 0, 0, 1'b0);
      drain();

      // random phases on small grids; last phase runs without idling
      for (int ph = 0; ph < 5; ph++) begin
         if (ph == 4) jitter_on = 1'b0;
         configure($urandom_range(1, 9), $urandom_range(1, 9),
                   (ph == 0) ? RULE_CONWAY : 18'($urandom), 1'($urandom),
                   $urandom_range(0, 7));
         for (int i = 0; i < 16; i++) begin
            int pick;
            pick = $urandom_range(0, 9);
            if (pick < 4)
               send(OP_WRITE, $urandom_range(0, cur_w - 1), $urandom_range(0, cur_h - 1),
                    1'($urandom));
            else if (pick < 6)
               send(OP_STEP, $urandom_range(0, 63), $urandom_range(0, 63), 1'($urandom));
            else if (pick < 8)
               send(OP_READ, $urandom_range(0, cur_w - 1), $urandom_range(0, cur_h - 1),
                    1'b0);
            else
               send(op_type'($urandom_range(0, 3)), $urandom_range(0, 63),
                    $urandom_range(0, 63), 1'($urandom));
         end
         drain();
      end

      repeat (20) @(posedge clock);
      $display("Run covered %0d words (%0d generation steps) over several grid sizes,",
               words_sent, steps_sent);
      $display("rules, history depths and period-search settings.");
      if (errors == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #6000000;
      $display("Verification failed");
      $finish;
   end

endmodule

@@ life_like_automaton_with_period_detect.f @@
rtl/lla_pkg.sv
rtl/lla_ram.sv
rtl/lla_ctrl.sv
rtl/lla_dp.sv
rtl/life_like_automaton_with_period_detect.sv
test/lla_checker.sv
test/tb.sv
